/* sv/rtms_pkg.sv */
// ----------------------------------------------------------------------------
// rtms_pkg: shared types for the range triple max segment tree
// Node record, combine function, command codes, state and micro-op codes.
// ----------------------------------------------------------------------------
`default_nettype none

package rtms_pkg;

  localparam int POSITIONS   = 1024;
  localparam int POS_W       = 11;
  localparam int VAL_W       = 28;
  localparam int SUM_W       = 32;
  localparam int OUT_W       = 31;
  localparam int NODE_W      = 11;
  localparam int NODES       = 2048;
  localparam int STACK_DEPTH = 12;
  localparam int SP_W        = 4;

  localparam logic signed [SUM_W-1:0] NEG_INF = -32'sd1000000000;

  typedef enum logic [1:0] {
    CMD_WRITE_A = 2'd0,
    CMD_WRITE_B = 2'd1,
    CMD_QUERY   = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_code_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] mx_a;
    logic signed [VAL_W-1:0] mn_b;
    logic signed [SUM_W-1:0] trio;
    logic signed [SUM_W-1:0] lp;
    logic signed [SUM_W-1:0] rp;
  } agg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_UPD_DOWN,
    ST_UPD_LEAF,
    ST_UPD_SIB,
    ST_UPD_PARENT,
    ST_Q_DOWN,
    ST_Q_LEFT,
    ST_Q_LFOLD,
    ST_Q_RIGHT,
    ST_Q_RFOLD,
    ST_Q_SFOLD
  } state_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_UPD_STEP,
    OP_LEAF_WRITE,
    OP_SIB_READ,
    OP_PARENT_WRITE,
    OP_Q_STEP,
    OP_L_STEP,
    OP_R_STEP,
    OP_FOLD_L,
    OP_FOLD_R,
    OP_SAVE_LEFT,
    OP_RES_EMPTY,
    OP_RES_SINGLE,
    OP_RES_JOIN
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic is_write;
    logic is_query;
    logic empty;
    logic leaf;
    logic at_root;
    logic parent_root;
    logic full;
    logic split;
    logic left_stop;
    logic right_stop;
    logic fold_done;
  } dp_status_t;

  function automatic logic signed [SUM_W-1:0] smax(input logic signed [SUM_W-1:0] a,
                                                   input logic signed [SUM_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  // combine the record of a left segment with the record of the segment on its right
  function automatic agg_t agg_join(input agg_t a, input agg_t b);
    agg_t r;
    logic signed [SUM_W-1:0] a_mx;
    logic signed [SUM_W-1:0] b_mx;
    logic signed [SUM_W-1:0] a_mn;
    logic signed [SUM_W-1:0] b_mn;
    a_mx = {{(SUM_W-VAL_W){a.mx_a[VAL_W-1]}}, a.mx_a};
    b_mx = {{(SUM_W-VAL_W){b.mx_a[VAL_W-1]}}, b.mx_a};
    a_mn = {{(SUM_W-VAL_W){a.mn_b[VAL_W-1]}}, a.mn_b};
    b_mn = {{(SUM_W-VAL_W){b.mn_b[VAL_W-1]}}, b.mn_b};
    r.mx_a = (a.mx_a > b.mx_a) ? a.mx_a : b.mx_a;
    r.mn_b = (a.mn_b < b.mn_b) ? a.mn_b : b.mn_b;
    r.trio = smax(smax(a.trio, b.trio), smax(a.lp + b_mx, a_mx + b.rp));
    r.lp   = smax(smax(a.lp, b.lp), a_mx - b_mn);
    r.rp   = smax(smax(a.rp, b.rp), b_mx - a_mn);
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/rtms_ctrl.sv */
// ----------------------------------------------------------------------------
// rtms_ctrl: sequencer for updates and range queries
// Walks the update path down and back up, and the query descent and folds.
// ----------------------------------------------------------------------------
`default_nettype none

module rtms_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  rtms_pkg::dp_status_t status,
  output rtms_pkg::dp_cmd_t    cmd,
  output logic                 busy
);
  import rtms_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_IDLE;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.op     = OP_LOAD;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (status.is_write) state_next = ST_UPD_DOWN;
        else if (status.is_query) state_next = ST_Q_DOWN;
        else state_next = ST_IDLE;
      end
      ST_UPD_DOWN: begin
        cmd.op = OP_UPD_STEP;
        if (status.leaf) state_next = ST_UPD_LEAF;
      end
      ST_UPD_LEAF: begin
        cmd.op     = OP_LEAF_WRITE;
        state_next = status.at_root ? ST_IDLE : ST_UPD_SIB;
      end
      ST_UPD_SIB: begin
        cmd.op     = OP_SIB_READ;
        state_next = ST_UPD_PARENT;
      end
      ST_UPD_PARENT: begin
        cmd.op     = OP_PARENT_WRITE;
        state_next = status.parent_root ? ST_IDLE : ST_UPD_SIB;
      end
      ST_Q_DOWN: begin
        if (status.empty) begin
          cmd.op     = OP_RES_EMPTY;
          state_next = ST_IDLE;
        end else begin
          cmd.op = OP_Q_STEP;
          if (status.full) state_next = ST_Q_SFOLD;
          else if (status.split) state_next = ST_Q_LEFT;
        end
      end
      ST_Q_LEFT: begin
        cmd.op = OP_L_STEP;
        if (status.left_stop) state_next = ST_Q_LFOLD;
      end
      ST_Q_LFOLD: begin
        if (status.fold_done) begin
          cmd.op     = OP_SAVE_LEFT;
          state_next = ST_Q_RIGHT;
        end else begin
          cmd.op = OP_FOLD_L;
        end
      end
      ST_Q_RIGHT: begin
        cmd.op = OP_R_STEP;
        if (status.right_stop) state_next = ST_Q_RFOLD;
      end
      ST_Q_RFOLD: begin
        if (status.fold_done) begin
          cmd.op     = OP_RES_JOIN;
          state_next = ST_IDLE;
        end else begin
          cmd.op = OP_FOLD_R;
        end
      end
      ST_Q_SFOLD: begin
        if (status.fold_done) begin
          cmd.op     = OP_RES_SINGLE;
          state_next = ST_IDLE;
        end else begin
          cmd.op = OP_FOLD_L;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign busy = (state != ST_IDLE);

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");
`endif

endmodule

`default_nettype wire

/* sv/rtms_datapath.sv */
// ----------------------------------------------------------------------------
// rtms_datapath: node memory, walk registers, node stack and combine unit
// Executes one micro-op per cycle as chosen by the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module rtms_datapath (
  input  logic                                       clk,
  input  logic                                       rst,
  input  rtms_pkg::dp_cmd_t                          cmd,
  output rtms_pkg::dp_status_t                       status,
  input  logic [1:0]                                 command,
  input  logic [rtms_pkg::POS_W-1:0]                 position,
  input  logic signed [rtms_pkg::VAL_W-1:0]          value,
  input  logic [rtms_pkg::POS_W-1:0]                 range_left,
  input  logic [rtms_pkg::POS_W-1:0]                 range_right,
  input  logic                                       cfg_we,
  input  logic [rtms_pkg::POS_W-1:0]                 cfg_wdata,
  output logic                                       done,
  output logic signed [rtms_pkg::OUT_W-1:0]          best_sum
);
  import rtms_pkg::*;

  agg_t                    mem [NODES];
  agg_t                    rd;
  logic [NODE_W-1:0]       mem_raddr;
  logic [NODE_W-1:0]       mem_waddr;
  agg_t                    mem_wdata;
  logic                    mem_we;

  logic [POS_W-1:0]        size_q;
  logic [POS_W-1:0]        n_eff;
  logic [POS_W-1:0]        s_in;
  logic [POS_W-1:0]        t_in;

  logic                    is_write_q;
  logic                    is_query_q;
  logic                    empty_q;
  logic                    is_b_q;
  logic [POS_W-1:0]        pos_q;
  logic signed [VAL_W-1:0] val_q;
  logic [POS_W-1:0]        s_q;
  logic [POS_W-1:0]        t_q;

  logic [NODE_W-1:0]       node;
  logic [POS_W-1:0]        lo;
  logic [POS_W-1:0]        hi;
  logic [NODE_W-1:0]       rnode;
  logic [POS_W-1:0]        rlo;
  logic [POS_W-1:0]        rhi;

  logic [NODE_W-1:0]       stack [STACK_DEPTH];
  logic [SP_W-1:0]         sp;
  logic [SP_W-1:0]         sp_m1;
  logic                    fold_pop;

  agg_t                    acc;
  agg_t                    lacc;
  agg_t                    leaf_new;
  agg_t                    join_up;
  agg_t                    fold_join;
  agg_t                    fin;
  logic                    rd_pend;
  logic                    rd_first;

  logic [POS_W:0]          lo_hi_sum;
  logic [POS_W-1:0]        mid;
  logic [POS_W-1:0]        mid_p1;
  logic [NODE_W-1:0]       child_l;
  logic [NODE_W-1:0]       child_r;
  logic                    full;
  logic                    left_stop;
  logic                    right_stop;
  logic                    push;
  logic [NODE_W-1:0]       push_node;

  // size register: zero acts as one, above the tree size acts as the tree size
  always_comb begin
    if (size_q == '0) n_eff = POS_W'(1);
    else if (size_q > POS_W'(POSITIONS)) n_eff = POS_W'(POSITIONS);
    else n_eff = size_q;
    s_in = (range_left == '0) ? POS_W'(1) : range_left;
    t_in = (range_right > n_eff) ? n_eff : range_right;
  end

  assign lo_hi_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid        = lo_hi_sum[POS_W:1];
  assign mid_p1     = mid + POS_W'(1);
  assign child_l    = {node[NODE_W-2:0], 1'b0};
  assign child_r    = {node[NODE_W-2:0], 1'b1};
  assign left_stop  = (s_q <= lo);
  assign right_stop = (hi <= t_q);
  assign full       = left_stop && right_stop;
  assign sp_m1      = sp - SP_W'(1);
  assign fold_pop   = ((cmd.op == OP_FOLD_L) || (cmd.op == OP_FOLD_R)) && (sp != '0);

  always_comb begin
    leaf_new = rd;
    if (is_b_q) leaf_new.mn_b = val_q;
    else leaf_new.mx_a = val_q;
    leaf_new.trio = NEG_INF;
    leaf_new.lp   = NEG_INF;
    leaf_new.rp   = NEG_INF;
  end

  // odd node is a right child: the stored sibling goes on the left
  assign join_up   = node[0] ? agg_join(rd, acc) : agg_join(acc, rd);
  assign fold_join = (cmd.op == OP_FOLD_R) ? agg_join(rd, acc) : agg_join(acc, rd);
  assign fin       = agg_join(lacc, acc);

  // push decision for the three descent micro-ops
  always_comb begin
    push      = 1'b0;
    push_node = node;
    case (cmd.op)
      OP_Q_STEP: push = full;
      OP_L_STEP: begin
        push      = left_stop || (s_q <= mid);
        push_node = left_stop ? node : child_r;
      end
      OP_R_STEP: begin
        push      = right_stop || (t_q > mid);
        push_node = right_stop ? node : child_l;
      end
      default: push = 1'b0;
    endcase
  end

  always_comb begin
    mem_raddr = node;
    mem_waddr = node;
    mem_wdata = leaf_new;
    mem_we    = 1'b0;
    unique case (cmd.op)
      OP_SIB_READ: mem_raddr = {node[NODE_W-1:1], ~node[0]};
      OP_FOLD_L, OP_FOLD_R: begin
        if (sp != '0) mem_raddr = stack[sp_m1];
      end
      OP_LEAF_WRITE: mem_we = 1'b1;
      OP_PARENT_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = {1'b0, node[NODE_W-1:1]};
        mem_wdata = join_up;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd <= mem[mem_raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      size_q  <= POS_W'(POSITIONS);
      sp      <= '0;
      rd_pend <= 1'b0;
      done    <= 1'b0;
    end else begin
      if (cfg_we) size_q <= cfg_wdata;
      done    <= (cmd.op == OP_RES_EMPTY) || (cmd.op == OP_RES_SINGLE) ||
                 (cmd.op == OP_RES_JOIN);
      rd_pend <= fold_pop;
      if (cmd.op == OP_LOAD) sp <= '0;
      else if (push) sp <= sp + SP_W'(1);
      else if (fold_pop) sp <= sp_m1;
    end
  end

  // walk, stack and accumulator registers
  always_ff @(posedge clk) begin
    if (push) stack[sp] <= push_node;
    unique case (cmd.op)
      OP_LOAD: begin
        is_write_q <= ((command == CMD_WRITE_A) || (command == CMD_WRITE_B)) &&
                      (position != '0) && (position <= n_eff);
        is_query_q <= (command == CMD_QUERY);
        is_b_q     <= (command == CMD_WRITE_B);
        empty_q    <= (s_in > t_in);
        pos_q      <= position;
        val_q      <= value;
        s_q        <= s_in;
        t_q        <= t_in;
        node       <= NODE_W'(1);
        lo         <= POS_W'(1);
        hi         <= n_eff;
      end
      OP_UPD_STEP: begin
        if (lo != hi) begin
          if (pos_q <= mid) begin
            node <= child_l;
            hi   <= mid;
          end else begin
            node <= child_r;
            lo   <= mid_p1;
          end
        end
      end
      OP_LEAF_WRITE: acc <= leaf_new;
      OP_PARENT_WRITE: begin
        acc  <= join_up;
        node <= {1'b0, node[NODE_W-1:1]};
      end
      OP_Q_STEP: begin
        rd_first <= 1'b1;
        if (!full) begin
          if (t_q <= mid) begin
            node <= child_l;
            hi   <= mid;
          end else if (s_q > mid) begin
            node <= child_r;
            lo   <= mid_p1;
          end else begin
            // split node: the right half is walked after the left fold
            rnode <= child_r;
            rlo   <= mid_p1;
            rhi   <= hi;
            node  <= child_l;
            hi    <= mid;
          end
        end
      end
      OP_L_STEP: begin
        rd_first <= 1'b1;
        if (!left_stop) begin
          if (s_q > mid) begin
            node <= child_r;
            lo   <= mid_p1;
          end else begin
            node <= child_l;
            hi   <= mid;
          end
        end
      end
      OP_R_STEP: begin
        rd_first <= 1'b1;
        if (!right_stop) begin
          if (t_q <= mid) begin
            node <= child_l;
            hi   <= mid;
          end else begin
            node <= child_r;
            lo   <= mid_p1;
          end
        end
      end
      OP_SAVE_LEFT: begin
        lacc     <= acc;
        node     <= rnode;
        lo       <= rlo;
        hi       <= rhi;
        rd_first <= 1'b1;
      end
      OP_RES_EMPTY:  best_sum <= NEG_INF[OUT_W-1:0];
      OP_RES_SINGLE: best_sum <= acc.trio[OUT_W-1:0];
      OP_RES_JOIN:   best_sum <= fin.trio[OUT_W-1:0];
      default: ;
    endcase
    // stacked nodes come back deepest first
    if (rd_pend) begin
      acc      <= rd_first ? rd : fold_join;
      rd_first <= 1'b0;
    end
  end

  always_comb begin
    status.is_write    = is_write_q;
    status.is_query    = is_query_q;
    status.empty       = empty_q;
    status.leaf        = (lo == hi);
    status.at_root     = (node == NODE_W'(1));
    status.parent_root = (node[NODE_W-1:1] == (NODE_W-1)'(1));
    status.full        = full;
    status.split       = !full && (s_q <= mid) && (t_q > mid);
    status.left_stop   = left_stop;
    status.right_stop  = right_stop;
    status.fold_done   = (sp == '0) && !rd_pend;
  end

`ifndef SYNTH
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= SP_W'(STACK_DEPTH))
    else $error("node stack overflow");
  a_read_from_fold: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> $past(cmd.op == OP_FOLD_L || cmd.op == OP_FOLD_R))
    else $error("fold read pending without a fold pop");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");
`endif

endmodule

`default_nettype wire

/* sv/range_triple_max_segment_tree.sv */
// ----------------------------------------------------------------------------
// range_triple_max_segment_tree: segment tree over arrays A and B
// Point writes of A or B and range queries for max A[i]-B[j]+A[k], i<j<k.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy stays high until
// the item is finished. A query gives one result on best_sum with done high
// for exactly one cycle and the receiver cannot hold it off; writes and the
// unused command give no result. All node records sit in one single-port
// read, single-port write memory. A write steps down one tree level at a
// time to the leaf and writes it, then reads the sibling and writes the
// parent at each level on the way up. A query on an empty range ends with
// no descent; any other query descends one level at a time and folds the
// stacked nodes one by one, for a split range first on the left side, then
// on the right side, and joins the two. The tree is not cleared at reset:
// write A and B at every position in use before the first query.
`default_nettype none

module range_triple_max_segment_tree (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          command,
  input  logic [rtms_pkg::POS_W-1:0]          position,
  input  logic signed [rtms_pkg::VAL_W-1:0]   value,
  input  logic [rtms_pkg::POS_W-1:0]          range_left,
  input  logic [rtms_pkg::POS_W-1:0]          range_right,
  input  logic                                cfg_we,
  input  logic [rtms_pkg::POS_W-1:0]          cfg_wdata,
  output logic                                done,
  output logic signed [rtms_pkg::OUT_W-1:0]   best_sum
);
  import rtms_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  rtms_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (dp_status),
    .cmd    (dp_cmd),
    .busy   (busy)
  );

  rtms_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (dp_cmd),
    .status      (dp_status),
    .command     (command),
    .position    (position),
    .value       (value),
    .range_left  (range_left),
    .range_right (range_right),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .done        (done),
    .best_sum    (best_sum)
  );

endmodule

`default_nettype wire
